// ----- hw/rtl/tnl_pkg.sv -----
// ----------------------------------------------------------------------------
// tnl_pkg: shared types and constants of the largest-entry tracker
// Item, result and store-entry layouts, configuration register map and codes.
// ----------------------------------------------------------------------------
package tnl_pkg;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam logic [2:0] REG_MAX_COUNT    = 3'd0;
	localparam logic [2:0] REG_FILTER_OWNER = 3'd1;
	localparam logic [2:0] REG_OWNER_MATCH  = 3'd2;
	localparam logic [2:0] REG_SAME_FS_ONLY = 3'd3;
	localparam logic [2:0] REG_FS_DEVICE    = 3'd4;
	localparam logic [2:0] REG_AGE_LIMIT    = 3'd5;

	localparam logic [1:0] OP_OFFER = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] KIND_REGULAR = 2'd0;
	localparam logic [1:0] KIND_LINK    = 2'd1;
	localparam logic [1:0] KIND_OTHER   = 2'd2;
	localparam logic [1:0] KIND_DIR     = 2'd3;

	localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

	localparam logic [4:0]  MAX_COUNT_RST = 5'd15;
	localparam logic [15:0] AGE_LIMIT_RST = 16'd30;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [47:0] file_size;
		logic [39:0] access_time;
		logic [15:0] entry_tag;
		logic [31:0] owner_id;
		logic [31:0] device_id;
		logic [1:0]  entry_kind;
		logic [3:0]  rank_index;
		logic [39:0] now_time;
	} item_t;

	typedef struct packed {
		logic        accepted;
		logic [3:0]  insert_rank;
		logic [31:0] files_seen;
		logic [63:0] total_size;
		logic [4:0]  kept_count;
		logic        entry_valid;
		logic [47:0] entry_size;
		logic [39:0] entry_time;
		logic [15:0] entry_id;
		logic        entry_old;
	} result_t;

	typedef struct packed {
		logic [47:0] size;
		logic [39:0] atime;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic [4:0]  max_count;
		logic        filter_owner;
		logic [31:0] owner_match;
		logic        same_fs_only;
		logic [31:0] fs_device;
		logic [15:0] age_limit_days;
	} cfg_t;

endpackage

// ----- hw/rtl/tnl_ram.sv -----
// ----------------------------------------------------------------------------
// tnl_ram: generic single-port RAM
// One read or write per cycle; read data is registered.
// ----------------------------------------------------------------------------
module tnl_ram #(
	parameter int WIDTH = 104,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ----- hw/rtl/tnl_cfg.sv -----
// ----------------------------------------------------------------------------
// tnl_cfg: configuration register bank
// APB-style slave holding the tracker's six configuration registers.
// ----------------------------------------------------------------------------
module tnl_cfg
	import tnl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_count      <= MAX_COUNT_RST;
			cfg_q.filter_owner   <= 1'b0;
			cfg_q.owner_match    <= '0;
			cfg_q.same_fs_only   <= 1'b0;
			cfg_q.fs_device      <= '0;
			cfg_q.age_limit_days <= AGE_LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_COUNT:    cfg_q.max_count      <= pwdata[4:0];
				REG_FILTER_OWNER: cfg_q.filter_owner   <= pwdata[0];
				REG_OWNER_MATCH:  cfg_q.owner_match    <= pwdata;
				REG_SAME_FS_ONLY: cfg_q.same_fs_only   <= pwdata[0];
				REG_FS_DEVICE:    cfg_q.fs_device      <= pwdata;
				REG_AGE_LIMIT:    cfg_q.age_limit_days <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_COUNT:    prdata = DATA_W'(cfg_q.max_count);
			REG_FILTER_OWNER: prdata = DATA_W'(cfg_q.filter_owner);
			REG_OWNER_MATCH:  prdata = cfg_q.owner_match;
			REG_SAME_FS_ONLY: prdata = DATA_W'(cfg_q.same_fs_only);
			REG_FS_DEVICE:    prdata = cfg_q.fs_device;
			REG_AGE_LIMIT:    prdata = DATA_W'(cfg_q.age_limit_days);
			default:          prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/top_n_largest_tracker.sv -----
// ----------------------------------------------------------------------------
// top_n_largest_tracker: keeps the largest offered entries in size order
// Sequencer around one size comparator and a single-port entry store.
// ----------------------------------------------------------------------------
// Usage. An item (offer, read or clear) is taken at a rising edge with start
// high and busy low; busy then stays high until the result has been built.
// Every item gives exactly one result, shown on result for one cycle with
// done high; the receiver cannot stall it, so it must take it there and then.
// Configuration goes through the APB-style port while the block is idle; the
// block itself does not enforce this, so the user must keep to it.
// Path of an item: clear, unused codes, reads beyond the kept entries and
// offers that do not reach the store go from decode straight to finish;
// reads of a kept entry pass a read-wait step, and offers to a full store
// pass a full check of the last kept entry, which turns them away unless
// they are larger. A placed offer runs the insertion loop, which reads one
// stored entry, compares it and writes it one rank lower, through the
// single port of the entry store, until the new entry's rank is found.
// A new item may be started in the cycle in which done is high.
// Reset empties the store and clears both counters; configuration registers
// return to their defaults. Store contents are not cleared.
// ----------------------------------------------------------------------------
module top_n_largest_tracker
	import tnl_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              done,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CW    = (OCC_W > 5) ? OCC_W : 5;
	localparam int EW    = $bits(entry_t);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_DECODE    = 3'd1;
	localparam logic [2:0] ST_FULL_CHK  = 3'd2;
	localparam logic [2:0] ST_SHIFT_RD  = 3'd3;
	localparam logic [2:0] ST_SHIFT_CMP = 3'd4;
	localparam logic [2:0] ST_READ_WAIT = 3'd5;
	localparam logic [2:0] ST_FINISH    = 3'd6;

	cfg_t cfg;

	tnl_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Control state
	logic [2:0]       state_q;
	logic             done_q;
	logic [OCC_W-1:0] occ_q;
	logic [31:0]      files_q;
	logic [63:0]      total_q;
	logic [OCC_W-1:0] j_q;
	logic             grow_q;

	// Payload
	item_t            item_q;
	logic [32:0]      lim_q;
	logic             acc_q;
	logic [OCC_W-1:0] pos_q;
	logic             ent_valid_q;
	entry_t           ent_q;
	logic             old_q;
	result_t          result_q;

	// Store port
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	entry_t           ram_wdata;
	logic [EW-1:0]    ram_rdata_raw;
	entry_t           ram_rdata;

	tnl_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = entry_t'(ram_rdata_raw);

	logic          dev_ok;
	logic          counted;
	logic          qualifies;
	logic [CW-1:0] limit;
	logic          room;
	logic          rank_hit;
	logic          size_gt;
	logic [64:0]   sum_c;
	logic [63:0]   total_next;
	logic          is_old;
	logic [39:0]   age_c;
	entry_t        new_entry;

	assign dev_ok    = !(cfg.same_fs_only && (item_q.device_id != cfg.fs_device));
	assign counted   = dev_ok && (item_q.entry_kind != KIND_DIR);
	assign qualifies = counted
		&& ((item_q.entry_kind == KIND_REGULAR) || (item_q.entry_kind == KIND_LINK))
		&& !(cfg.filter_owner && (item_q.owner_id != cfg.owner_match));

	always_comb begin
		if (cfg.max_count == '0) begin
			limit = CW'(1);
		end else if (CW'(cfg.max_count) > CW'(DEPTH)) begin
			limit = CW'(DEPTH);
		end else begin
			limit = CW'(cfg.max_count);
		end
	end

	// A store at or above the current limit counts as full, even after the
	// limit has been lowered below the occupancy.
	assign room     = CW'(occ_q) < limit;
	assign rank_hit = CW'(item_q.rank_index) < CW'(occ_q);

	// The one comparator shared by the full check and the insertion loop.
	assign size_gt = item_q.file_size > ram_rdata.size;

	assign sum_c      = {1'b0, total_q} + 65'(item_q.file_size);
	assign total_next = sum_c[64] ? '1 : sum_c[63:0];

	assign age_c  = item_q.now_time - ram_rdata.atime;
	assign is_old = (item_q.now_time > ram_rdata.atime) && (age_c > 40'(lim_q));

	assign new_entry.size  = item_q.file_size;
	assign new_entry.atime = item_q.access_time;
	assign new_entry.tag   = item_q.entry_tag;

	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = '0;
		ram_wdata = new_entry;
		case (state_q)
			ST_DECODE: begin
				if (item_q.opcode == OP_READ) begin
					ram_addr = AW'(item_q.rank_index);
				end else begin
					ram_addr = AW'(occ_q - 1'b1);
				end
			end
			ST_SHIFT_RD: begin
				if (j_q == '0) begin
					ram_we = 1'b1;
				end else begin
					ram_addr = AW'(j_q - 1'b1);
				end
			end
			ST_SHIFT_CMP: begin
				ram_we   = 1'b1;
				ram_addr = AW'(j_q);
				if (size_gt) begin
					ram_wdata = ram_rdata;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			occ_q   <= '0;
			files_q <= '0;
			total_q <= '0;
			j_q     <= '0;
			grow_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_FINISH;
					case (item_q.opcode)
						OP_OFFER: begin
							if (counted && (files_q != '1)) begin
								files_q <= files_q + 1'b1;
							end
							if (qualifies) begin
								total_q <= total_next;
								grow_q  <= room;
								j_q     <= room ? occ_q : occ_q - 1'b1;
								state_q <= room ? ST_SHIFT_RD : ST_FULL_CHK;
							end
						end
						OP_READ: begin
							if (rank_hit) begin
								state_q <= ST_READ_WAIT;
							end
						end
						OP_CLEAR: begin
							occ_q   <= '0;
							files_q <= '0;
							total_q <= '0;
						end
						default: ;
					endcase
				end
				ST_FULL_CHK: begin
					state_q <= size_gt ? ST_SHIFT_RD : ST_FINISH;
				end
				ST_SHIFT_RD: begin
					if (j_q == '0) begin
						if (grow_q) begin
							occ_q <= occ_q + 1'b1;
						end
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_SHIFT_CMP;
					end
				end
				ST_SHIFT_CMP: begin
					if (!size_gt) begin
						if (grow_q) begin
							occ_q <= occ_q + 1'b1;
						end
						state_q <= ST_FINISH;
					end else begin
						j_q     <= j_q - 1'b1;
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_READ_WAIT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_q <= item;
				end
			end
			ST_DECODE: begin
				acc_q       <= 1'b0;
				pos_q       <= '0;
				ent_valid_q <= 1'b0;
				ent_q       <= '0;
				old_q       <= 1'b0;
				lim_q       <= 33'(cfg.age_limit_days) * 33'(SECONDS_PER_DAY);
			end
			default: ;
		endcase
		case (state_q)
			ST_SHIFT_RD: begin
				if (j_q == '0) begin
					acc_q <= 1'b1;
					pos_q <= '0;
				end
			end
			ST_SHIFT_CMP: begin
				if (!size_gt) begin
					acc_q <= 1'b1;
					pos_q <= j_q;
				end
			end
			ST_READ_WAIT: begin
				ent_valid_q <= 1'b1;
				ent_q       <= ram_rdata;
				old_q       <= is_old;
			end
			ST_FINISH: begin
				result_q.accepted    <= acc_q;
				result_q.insert_rank <= 4'(pos_q);
				result_q.files_seen  <= files_q;
				result_q.total_size  <= total_q;
				result_q.kept_count  <= 5'(occ_q);
				result_q.entry_valid <= ent_valid_q;
				result_q.entry_size  <= ent_q.size;
				result_q.entry_time  <= ent_q.atime;
				result_q.entry_id    <= ent_q.tag;
				result_q.entry_old   <= old_q;
			end
			default: ;
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	a_start_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_DECODE))
		else $error("accepted item did not enter decode");

	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("done raised outside the finish step");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW'(occ_q) <= CW'(DEPTH)))
		else $error("occupancy beyond store depth");

	a_write_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ((state_q == ST_SHIFT_RD) || (state_q == ST_SHIFT_CMP)))
		else $error("store written outside the insertion loop");

	a_rank_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && acc_q) |-> (pos_q < occ_q))
		else $error("placed rank outside the kept entries");

endmodule
